/* rtl/positional_array_list_macros.svh */
// Assertion helpers used by the list RTL
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// same-cycle implication, quiet while in reset
`define PAL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pal_pkg.sv */
`timescale 1ns / 1ps

package pal_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int GRP     = 8;
  localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 16;
  localparam int CAP_W   = 7;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic REG_CAP = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  pos;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

/* rtl/pal_cell.sv */
`timescale 1ns / 1ps

module pal_cell import pal_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [WORD_W-1:0] prev_word,
  input  logic [WORD_W-1:0] next_word,
  output logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] tap
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        word_nxt = ctl.value;
      end else if (idx > ctl.pos) begin
        word_nxt = prev_word;
      end
    end else if (ctl.del) begin
      if (idx >= ctl.pos) begin
        word_nxt = next_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  // only the addressed cell puts its word on the read tap
  assign tap  = (idx == ctl.pos) ? word_r : '0;

endmodule

/* rtl/pal_tap_or.sv */
`timescale 1ns / 1ps

module pal_tap_or import pal_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] taps [GRP],
  output logic [WORD_W-1:0] merged
);

  logic [WORD_W-1:0] merged_r;
  logic [WORD_W-1:0] merged_nxt;

  always_comb begin
    merged_nxt = '0;
    for (int k = 0; k < GRP; k++) begin
      merged_nxt = merged_nxt | taps[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      merged_r <= merged_nxt;
    end
  end

  assign merged = merged_r;

endmodule

/* rtl/positional_array_list.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | word
// in_     | in        | in_valid / in_stall   | kind, position, value
// out_    | out       | out_valid / out_stall | read_value, status, count_after
// cfg     | in        | APB psel/penable      | capacity_limit at byte 0
// One item in flight: accept, execute (cells shift, group read taps registered),
// finish (final OR into the output register). A new item is accepted only once
// the last has left finish; finish waits while the output register is still held.
// A new word is taken while a finished result still waits in the output register.
// Synchronous active-low reset empties the list; cell contents are not cleared.

`include "positional_array_list_macros.svh"

module positional_array_list import pal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [POS_W-1:0]  in_position,
  input  logic [WORD_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_read_value,
  output logic [1:0]        out_status,
  output logic [6:0]        out_count_after,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [1:0]        kind_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] val_r;
  logic [1:0]        status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_val_r;
  logic [1:0]        out_status_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              in_acc;
  logic              out_free;
  logic [POS_W-1:0]  lim16, cnt16, pos_c;
  cell_ctl_t         ctl;

  logic [WORD_W-1:0] words [DEPTH];
  logic [WORD_W-1:0] taps  [NGRP*GRP];
  logic [WORD_W-1:0] grp_or [NGRP];
  logic [WORD_W-1:0] rd_word;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAP) ? {{(32-CAP_W){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAP) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // limit in force is the smaller of the register and the store depth
  always_comb begin
    lim16 = {{(POS_W-CAP_W){1'b0}}, cap_r};
    if (lim16 > POS_W'(DEPTH)) begin
      lim16 = POS_W'(DEPTH);
    end
    cnt16 = POS_W'(count_r);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    pos_c         = pos_r;
    ctl.ins       = 1'b0;
    ctl.del       = 1'b0;
    ctl.value     = val_r;

    case (kind_r)
      KIND_INSERT: begin
        if (pos_r > cnt16) begin
          pos_c = cnt16;
        end
      end
      KIND_READ, KIND_DELETE: begin
        if (pos_r >= cnt16) begin
          pos_c = cnt16 - POS_W'(1);
        end
      end
      default: pos_c = pos_r;
    endcase
    ctl.pos = pos_c[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt  = ST_FIN;
        status_nxt = STATUS_OK;
        rd_ok_nxt  = 1'b0;
        case (kind_r)
          KIND_INSERT: begin
            if (cnt16 >= lim16) begin
              status_nxt = STATUS_FULL;
            end else begin
              ctl.ins   = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          KIND_READ, KIND_DELETE: begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
            end else begin
              rd_ok_nxt = 1'b1;
              if (kind_r == KIND_DELETE) begin
                ctl.del   = 1'b1;
                count_nxt = count_r - CNT_W'(1);
              end
            end
          end
          default: count_nxt = '0;
        endcase
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STATUS_OK;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      rd_ok_r     <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
    if (state_r == ST_FIN && out_free) begin
      out_val_r    <= rd_ok_r ? rd_word : '0;
      out_status_r <= status_r;
      out_count_r  <= count_r;
    end
  end

  // row of cells; each shifts from a neighbour under the broadcast control
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = words[i];
    end else begin : g_body
      assign next_w = words[i+1];
    end
    pal_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IDX_W'(i)),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (words[i]),
      .tap       (taps[i])
    );
  end

  for (genvar i = DEPTH; i < NGRP*GRP; i++) begin : g_pad
    assign taps[i] = '0;
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    pal_tap_or u_or (
      .clk    (clk),
      .en     (state_r == ST_EXEC),
      .taps   (taps[g*GRP +: GRP]),
      .merged (grp_or[g])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_or[g];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_val_r;
  assign out_status      = out_status_r;
  assign out_count_after = 7'(out_count_r);

  `PAL_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count beyond depth")
  `PAL_ASSERT_NEXT(a_accept_exec, in_acc, state_r == ST_EXEC, "accept did not start execute")
  `PAL_ASSERT_IMPL(a_rose_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN,
                   "result appeared outside finish")
  `PAL_ASSERT_IMPL(a_err_zero, out_valid_r && out_status_r != STATUS_OK, out_val_r == '0,
                   "error result carries data")

endmodule

/* verif/tb_positional_array_list.sv */
`timescale 1ns / 1ps

module tb_positional_array_list import pal_pkg::*; ();

  typedef struct packed {
    logic [1:0]        kind;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic [1:0]        status;
    logic [6:0]        count_after;
  } list_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_kind = KIND_CLEAR;
  logic [POS_W-1:0]  in_position = '0;
  logic [WORD_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_read_value;
  logic [1:0]        out_status;
  logic [6:0]        out_count_after;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  positional_array_list dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count_after(out_count_after),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // shadow of the list and its limit register
  logic [WORD_W-1:0] list_store [DEPTH];
  int                list_len = 0;
  logic [CAP_W-1:0]  cap_shadow = CAP_RESET;

  list_op_t    op_q[$];
  list_reply_t pending_replies[$];
  list_op_t    cur_op;

  int mismatches = 0;
  int words_in = 0;
  int results_seen = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int peak_len = 0;
  int cap_writes = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit feed_burst = 1'b0;
  bit drain_burst = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_positional_array_list: FAIL");
    $finish;
  end

  function automatic list_reply_t apply_list_op(list_op_t op);
    list_reply_t rep;
    int          lim;
    int          p;
    rep = '0;
    lim = (cap_shadow > DEPTH) ? DEPTH : int'(cap_shadow);
    p = op.position;
    case (op.kind)
      KIND_INSERT: begin
        if (list_len >= lim) begin
          rep.status = STATUS_FULL;
        end else begin
          if (p > list_len) p = list_len;
          for (int i = list_len; i > p; i--) list_store[i] = list_store[i-1];
          list_store[p] = op.value;
          list_len++;
        end
      end
      KIND_READ, KIND_DELETE: begin
        if (list_len == 0) begin
          rep.status = STATUS_EMPTY;
        end else begin
          if (p >= list_len) p = list_len - 1;
          rep.read_value = list_store[p];
          if (op.kind == KIND_DELETE) begin
            for (int i = p + 1; i < list_len; i++) list_store[i-1] = list_store[i];
            list_len--;
          end
        end
      end
      default: list_len = 0;
    endcase
    rep.count_after = list_len[6:0];
    if (rep.status == STATUS_FULL) full_seen++;
    if (rep.status == STATUS_EMPTY) empty_seen++;
    if (list_len > peak_len) peak_len = list_len;
    return rep;
  endfunction

  function automatic list_op_t random_op(bit filling);
    list_op_t op;
    int       r;
    int       s;
    r = $urandom_range(0, 99);
    if (filling)
      op.kind = (r < 70) ? KIND_INSERT : (r < 84) ? KIND_READ :
                (r < 99) ? KIND_DELETE : KIND_CLEAR;
    else
      op.kind = (r < 35) ? KIND_INSERT : (r < 65) ? KIND_READ :
                (r < 97) ? KIND_DELETE : KIND_CLEAR;
    s = $urandom_range(0, 19);
    if (s < 11) op.position = POS_W'($urandom_range(0, 70));
    else if (s < 14) op.position = '1;
    else if (s < 15) op.position = '0;
    else op.position = POS_W'($urandom());
    s = $urandom_range(0, 9);
    if (s == 0) op.value = '0;
    else if (s == 1) op.value = '1;
    else op.value = $urandom();
    return op;
  endfunction

  task automatic queue_op(logic [1:0] kind, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
    op_q.push_back('{kind, pos, val});
  endtask

  // wait until every queued word has gone through and come back, plus pipeline slack
  task automatic settle();
    while (op_q.size() != 0 || in_valid || pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write the limit, then read it back
  task automatic set_capacity(logic [CAP_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAP, 2'b00};
    pwdata  <= {$urandom_range(0, 1) ? 25'($urandom()) : 25'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_shadow = v;
    cap_writes++;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {25'd0, cap_shadow}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("limit readback: expected %0d got %h", cap_shadow, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // input side
  always @(posedge clk) begin : feed
    logic take;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        pending_replies.push_back(apply_list_op(cur_op));
        words_in++;
      end
      if (!in_valid || take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_q.size() != 0) begin
          cur_op = op_q.pop_front();
          in_kind     <= cur_op.kind;
          in_position <= cur_op.position;
          in_value    <= cur_op.value;
          in_valid    <= 1'b1;
          if ($urandom_range(0, 79) == 0) feed_burst = !feed_burst;
          gap_left = feed_burst ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : check
    list_reply_t got;
    list_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_read_value, out_status, out_count_after};
        results_seen++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: value %h status %0d count %0d",
                     got.read_value, got.status, got.count_after);
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"word %0d: value exp %h got %h, status exp %0d got %0d, ",
                        "count exp %0d got %0d"},
                       results_seen, want.read_value, got.read_value, want.status, got.status,
                       want.count_after, got.count_after);
          end
        end
        if ($urandom_range(0, 79) == 0) drain_burst = !drain_burst;
        stall_left = drain_burst ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    logic [CAP_W-1:0] caps [8];
    logic [CAP_W-1:0] c;
    caps = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd3};
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, clamping at both ends, clear
    queue_op(KIND_READ,   16'd0,     32'h0);
    queue_op(KIND_DELETE, 16'hFFFF,  32'h0);
    queue_op(KIND_INSERT, 16'd0,     32'h0000_0000);
    queue_op(KIND_INSERT, 16'hFFFF,  32'hFFFF_FFFF);
    queue_op(KIND_INSERT, 16'd1,     32'h5A5A_A5A5);
    queue_op(KIND_READ,   16'hFFFF,  32'h1111_1111);
    queue_op(KIND_READ,   16'd0,     32'h0);
    queue_op(KIND_DELETE, 16'd1,     32'h0);
    queue_op(KIND_READ,   16'd1,     32'h0);
    queue_op(KIND_CLEAR,  16'd3,     32'hDEAD_BEEF);
    queue_op(KIND_READ,   16'd0,     32'h0);
    queue_op(KIND_INSERT, 16'd7,     32'h1234_5678);
    settle();
    // limit of one: insert refused while one entry is held, accepted after a delete
    set_capacity(7'd1);
    queue_op(KIND_INSERT, 16'd0,     32'hA5A5_0F0F);
    queue_op(KIND_DELETE, 16'd0,     32'h0);
    queue_op(KIND_INSERT, 16'd0,     32'hC3C3_3C3C);
    settle();
    // limit of zero refuses every insert
    set_capacity(7'd0);
    queue_op(KIND_INSERT, 16'd0,     32'h8000_0001);
    queue_op(KIND_READ,   16'd0,     32'h0);
    settle();
    set_capacity(7'd127);
    queue_op(KIND_INSERT, 16'd0,     32'h0F0F_F0F0);
    queue_op(KIND_INSERT, 16'd2,     32'h7FFF_FFFF);
    queue_op(KIND_INSERT, 16'd1,     32'h0000_FFFF);
    settle();
    // limit dropped below the current length
    set_capacity(7'd2);
    queue_op(KIND_INSERT, 16'd1,     32'hFFFF_0000);
    queue_op(KIND_DELETE, 16'd2,     32'h0);
    queue_op(KIND_INSERT, 16'd0,     32'h2468_ACE0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 8) c = caps[ph];
      else c = ($urandom_range(0, 3) == 0) ? 7'd64 : 7'($urandom_range(0, 127));
      set_capacity(c);
      for (int k = 0; k < 128; k++) op_q.push_back(random_op(ph % 2 == 0));
      settle();
    end

    repeat (10) @(posedge clk);
    if (pending_replies.size() != 0) mismatches++;
    $display("covered %0d words in, %0d results out, %0d refused as full, %0d on an empty list",
             words_in, results_seen, full_seen, empty_seen);
    $display("longest list %0d entries, %0d limit settings, %0d mismatches",
             peak_len, cap_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb_positional_array_list: PASS");
    end else begin
      $display("tb_positional_array_list: FAIL");
    end
    $finish;
  end

endmodule
